// File: rtl/tsr_pkg.sv
package tsr_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_SAMPLES = 16;
    localparam int FRAC_BITS   = 16;
    localparam int RCP_SCALE   = 46;

    localparam int VTX_W      = FRAC_BITS + 1;
    localparam int COORD_W    = 7;
    localparam int PIX_W      = 6;
    localparam int BARY_W     = FRAC_BITS + 1;
    localparam int SEED_W     = 32;
    localparam int SEED_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
    localparam int SEED_AW    = $clog2(SEED_DEPTH);
    localparam int BANK_DEPTH = SEED_DEPTH / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int SCNT_W     = 5;
    localparam int SIDX_W     = $clog2(MAX_SAMPLES);
    localparam int CFG_IW     = 2;
    localparam int CFG_DW     = 7;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_SEED = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SAMPLE_COUNT = 2'd2;

    typedef struct packed {
        cmd_code_t                   op;
        logic [5:0][VTX_W-1:0]       vtx;
        logic [SEED_AW-1:0]          seed_index;
        logic [SEED_W-1:0]           seed_value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

// File: rtl/tsr_ram.sv
module tsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// File: rtl/tsr_mul.sv
module tsr_mul (
    input  logic                               clk,
    input  logic signed [tsr_pkg::MUL_W-1:0]   a,
    input  logic signed [tsr_pkg::MUL_W-1:0]   b,
    output logic signed [tsr_pkg::PROD_W-1:0]  p_reg
);
    import tsr_pkg::*;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

endmodule

// File: rtl/tsr_front.sv
module tsr_front #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tsr_pkg::cmd_t      in_cmd,
    output logic               full,
    output tsr_pkg::cmd_beat_t head,
    input  logic               take
);
    import tsr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             keep, enq, deq;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // unknown codes and out-of-range seed writes are swallowed here
    always_comb
    begin
        keep = (in_cmd.op == CMD_LOAD) || (in_cmd.op == CMD_NEXT) ||
               ((in_cmd.op == CMD_SEED) &&
                ({1'b0, in_cmd.seed_index} < (SEED_AW + 1)'(SEED_DEPTH)));
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign enq        = push && !full && keep;
    assign deq        = take && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (deq)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (enq && !deq)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (deq && !enq)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/tsr_back.sv
module tsr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsr_pkg::cmd_beat_t            head,
    output logic                          take,
    input  logic                          cfg_we,
    input  logic [tsr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [tsr_pkg::CFG_DW-1:0]    cfg_data,
    output logic                          empty,
    input  logic                          pop,
    output logic                          hit,
    output logic                          done_res,
    output logic [tsr_pkg::PIX_W-1:0]     pixel_col,
    output logic [tsr_pkg::PIX_W-1:0]     pixel_row,
    output logic [tsr_pkg::BARY_W-1:0]    bary_v,
    output logic [tsr_pkg::BARY_W-1:0]    bary_w
);
    import tsr_pkg::*;

    localparam int SCALED_W = VTX_W + COORD_W;
    localparam int MAG_W    = 48;
    localparam int HALF_W   = MAG_W / 2;
    localparam int ACC_W    = 2 * MAG_W;
    localparam int SH_W     = 7;
    localparam int PT_W     = PIX_W + FRAC_BITS;
    localparam logic [BARY_W-1:0] ONE = BARY_W'(1 << FRAC_BITS);
    localparam logic [FRAC_BITS-1:0] CENTER = FRAC_BITS'(1 << (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE, ST_BOX, ST_AREA, ST_NORM, ST_DIV,
        ST_WALK, ST_POINT, ST_EDGE, ST_WEIGHT, ST_EMIT
    } state_t;

    state_t                       state_reg;
    logic [5:0]                   cnt_reg;
    logic [5:0][VTX_W-1:0]        vtx_reg;
    logic [5:0][SCALED_W-1:0]     v_reg;
    logic [COORD_W-1:0]           box_left_reg, box_right_reg, box_top_reg, box_bottom_reg;
    logic [COORD_W-1:0]           scan_col_reg, scan_row_reg;
    logic [SCNT_W-1:0]            sidx_reg;
    logic                         neg_reg;
    logic [MAG_W-1:0]             dmag_reg, rcp_reg, norm_reg;
    logic [SH_W-1:0]              shift_reg;
    logic [5:0]                   nshift_reg;
    logic [MAG_W:0]               rem_reg;
    logic signed [PROD_W-1:0]     t_reg, vn_reg, wn_reg;
    logic [PT_W-1:0]              px_reg, py_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic [BARY_W-1:0]            bv_reg, bw_reg;
    logic                         res_hit_reg;
    logic [COORD_W-1:0]           fw_reg, fh_reg;
    logic [SCNT_W-1:0]            sc_reg;
    logic                         out_valid_reg, out_hit_reg, out_done_reg;
    logic [PIX_W-1:0]             out_col_reg, out_row_reg;
    logic [BARY_W-1:0]            out_bv_reg, out_bw_reg;

    logic [COORD_W-1:0]           w_eff, h_eff;
    logic [SCNT_W-1:0]            s_eff;
    logic                         multi;
    logic [2*COORD_W-1:0]         pix_prod;
    logic [BANK_AW-1:0]           pix_addr;
    logic                         seed_wr;
    logic [SEED_W-1:0]            seed_x, seed_y, frac_x, frac_y;
    logic [FRAC_BITS-1:0]         off_x, off_y;
    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic [SCALED_W-1:0]          minx, maxx, miny, maxy;
    logic [COORD_W:0]             rx, ry;
    logic signed [MUL_W-1:0]      dx1, dy1, dx2, dy2;
    logic signed [MUL_W-1:0]      ex0, ex1, ex2, ey0, ey1, ey2;
    logic signed [PROD_W-1:0]     diff, diff_abs;
    logic [MAG_W:0]               vw_sum;
    logic                         covered;
    logic [2:0]                   scale_sel;
    logic [MAG_W-1:0]             wop;
    logic [1:0]                   prev_part;
    logic [6:0]                   psh;
    logic [ACC_W-1:0]             acc_sum, wq;
    logic [BARY_W-1:0]            wsat;
    logic [MAG_W:0]               r_sh;
    logic                         div_ge;
    logic                         out_free;
    logic                         emit_fire;

    function automatic logic [SEED_W-1:0] radinv(input logic [SIDX_W-1:0] n,
                                                  input logic [SEED_W-1:0] scr);
        logic [SEED_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIDX_W; i++)
        begin
            r[SEED_W-1-i] = n[i];
        end
        return r ^ scr;
    endfunction

    function automatic logic [SEED_W-1:0] sobol2(input logic [SIDX_W-1:0] n,
                                                  input logic [SEED_W-1:0] scr);
        logic [SEED_W-1:0] d;
        logic [SEED_W-1:0] s;
        d = {1'b1, {(SEED_W-1){1'b0}}};
        s = scr;
        for (int i = 0; i < SIDX_W; i++)
        begin
            if (n[i])
            begin
                s = s ^ d;
            end
            d = d ^ (d >> 1);
        end
        return s;
    endfunction

    function automatic logic [SCALED_W-1:0] min3(input logic [SCALED_W-1:0] a, b, c);
        logic [SCALED_W-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [SCALED_W-1:0] max3(input logic [SCALED_W-1:0] a, b, c);
        logic [SCALED_W-1:0] m;
        m = (b > a) ? b : a;
        return (c > m) ? c : m;
    endfunction

    function automatic logic signed [MUL_W-1:0] sub_pt(input logic [SCALED_W-1:0] v,
                                                       input logic [PT_W-1:0] p);
        return $signed(MUL_W'(v)) - $signed(MUL_W'(p));
    endfunction

    tsr_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    assign seed_wr = (state_reg == ST_IDLE) && head.valid && (head.cmd.op == CMD_SEED);
    assign take    = (state_reg == ST_IDLE) && head.valid;

    tsr_ram #(.WIDTH(SEED_W), .DEPTH(BANK_DEPTH)) u_seed_x (
        .clk       (clk),
        .we        (seed_wr && !head.cmd.seed_index[0]),
        .waddr     (head.cmd.seed_index[SEED_AW-1:1]),
        .wdata     (head.cmd.seed_value),
        .raddr     (pix_addr),
        .rdata_reg (seed_x)
    );

    tsr_ram #(.WIDTH(SEED_W), .DEPTH(BANK_DEPTH)) u_seed_y (
        .clk       (clk),
        .we        (seed_wr && head.cmd.seed_index[0]),
        .waddr     (head.cmd.seed_index[SEED_AW-1:1]),
        .wdata     (head.cmd.seed_value),
        .raddr     (pix_addr),
        .rdata_reg (seed_y)
    );

    always_comb
    begin
        w_eff = (fw_reg > COORD_W'(MAX_WIDTH)) ? COORD_W'(MAX_WIDTH) : fw_reg;
        h_eff = (fh_reg > COORD_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : fh_reg;
        if (sc_reg == '0)
        begin
            s_eff = SCNT_W'(1);
        end
        else
        begin
            s_eff = (sc_reg > SCNT_W'(MAX_SAMPLES)) ? SCNT_W'(MAX_SAMPLES) : sc_reg;
        end
        multi = (s_eff > SCNT_W'(1));

        // seed addressing wraps modulo the bank depth
        pix_prod = (2*COORD_W)'(scan_row_reg) * (2*COORD_W)'(w_eff);
        pix_addr = pix_prod[BANK_AW-1:0] + BANK_AW'(scan_col_reg);

        frac_x = radinv(sidx_reg[SIDX_W-1:0], seed_x);
        frac_y = sobol2(sidx_reg[SIDX_W-1:0], seed_y);
        off_x  = multi ? frac_x[SEED_W-1 -: FRAC_BITS] : CENTER;
        off_y  = multi ? frac_y[SEED_W-1 -: FRAC_BITS] : CENTER;

        minx = min3(v_reg[0], v_reg[2], v_reg[4]);
        maxx = max3(v_reg[0], v_reg[2], v_reg[4]);
        miny = min3(v_reg[1], v_reg[3], v_reg[5]);
        maxy = max3(v_reg[1], v_reg[3], v_reg[5]);
        rx   = {1'b0, maxx[FRAC_BITS+COORD_W-1:FRAC_BITS]} + (COORD_W+1)'(1);
        ry   = {1'b0, maxy[FRAC_BITS+COORD_W-1:FRAC_BITS]} + (COORD_W+1)'(1);

        dx1 = sub_pt(v_reg[2], '0) - sub_pt(v_reg[0], '0);
        dy1 = sub_pt(v_reg[3], '0) - sub_pt(v_reg[1], '0);
        dx2 = sub_pt(v_reg[4], '0) - sub_pt(v_reg[0], '0);
        dy2 = sub_pt(v_reg[5], '0) - sub_pt(v_reg[1], '0);
        ex0 = sub_pt(v_reg[0], px_reg);
        ex1 = sub_pt(v_reg[2], px_reg);
        ex2 = sub_pt(v_reg[4], px_reg);
        ey0 = sub_pt(v_reg[1], py_reg);
        ey1 = sub_pt(v_reg[3], py_reg);
        ey2 = sub_pt(v_reg[5], py_reg);

        diff     = t_reg - prod;
        diff_abs = neg_reg ? -diff : diff;
        vw_sum   = {1'b0, vn_reg[MAG_W-1:0]} + {1'b0, diff_abs[MAG_W-1:0]};
        covered  = !vn_reg[PROD_W-1] && !diff_abs[PROD_W-1] && (rcp_reg != '0) &&
                   (vw_sum <= {1'b0, dmag_reg});

        scale_sel = (cnt_reg < 6'd6) ? cnt_reg[2:0] : 3'd0;
        wop       = cnt_reg[2] ? wn_reg[MAG_W-1:0] : vn_reg[MAG_W-1:0];

        prev_part = 2'(cnt_reg - 6'd1);
        unique case (prev_part)
            2'd0:    psh = 7'd0;
            2'd3:    psh = 7'(2 * HALF_W);
            default: psh = 7'(HALF_W);
        endcase
        acc_sum = acc_reg + (ACC_W'(prod[MAG_W-1:0]) << psh);
        wq      = acc_sum >> shift_reg;
        wsat    = (wq > ACC_W'(ONE)) ? ONE : wq[BARY_W-1:0];

        r_sh   = (cnt_reg == '0) ? rem_reg : {rem_reg[MAG_W-1:0], 1'b0};
        div_ge = (r_sh >= {1'b0, norm_reg});

        out_free  = !out_valid_reg || pop;
        emit_fire = (state_reg == ST_EMIT) && out_free;

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SCALE:
            begin
                mul_a = $signed(MUL_W'(vtx_reg[scale_sel]));
                mul_b = $signed(MUL_W'(cnt_reg[0] ? h_eff : w_eff));
            end
            ST_AREA:
            begin
                mul_a = (cnt_reg == '0) ? dx1 : dx2;
                mul_b = (cnt_reg == '0) ? dy2 : dy1;
            end
            ST_EDGE:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:    begin mul_a = ex2; mul_b = ey0; end
                    2'd1:    begin mul_a = ex0; mul_b = ey2; end
                    2'd2:    begin mul_a = ex0; mul_b = ey1; end
                    default: begin mul_a = ex1; mul_b = ey0; end
                endcase
            end
            ST_WEIGHT:
            begin
                mul_a = $signed(MUL_W'(cnt_reg[1] ? wop[MAG_W-1:HALF_W] : wop[HALF_W-1:0]));
                mul_b = $signed(MUL_W'(cnt_reg[0] ? rcp_reg[MAG_W-1:HALF_W]
                                                  : rcp_reg[HALF_W-1:0]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            vtx_reg        <= '0;
            v_reg          <= '0;
            box_left_reg   <= '0;
            box_right_reg  <= '0;
            box_top_reg    <= '0;
            box_bottom_reg <= '0;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            sidx_reg       <= '0;
            neg_reg        <= 1'b0;
            dmag_reg       <= '0;
            rcp_reg        <= '0;
            norm_reg       <= '0;
            shift_reg      <= '0;
            nshift_reg     <= '0;
            rem_reg        <= '0;
            t_reg          <= '0;
            vn_reg         <= '0;
            wn_reg         <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            acc_reg        <= '0;
            bv_reg         <= '0;
            bw_reg         <= '0;
            res_hit_reg    <= 1'b0;
            fw_reg         <= COORD_W'(64);
            fh_reg         <= COORD_W'(64);
            sc_reg         <= SCNT_W'(1);
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_done_reg   <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_bv_reg     <= '0;
            out_bw_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    REG_SAMPLE_COUNT: sc_reg <= cfg_data[SCNT_W-1:0];
                    default:          ;
                endcase
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        unique case (head.cmd.op)
                            CMD_LOAD:
                            begin
                                vtx_reg   <= head.cmd.vtx;
                                cnt_reg   <= '0;
                                state_reg <= ST_SCALE;
                            end
                            CMD_NEXT: state_reg <= ST_WALK;
                            default:  ;
                        endcase
                    end
                end
                ST_SCALE:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg != '0)
                    begin
                        v_reg[cnt_reg[2:0] - 3'd1] <= prod[SCALED_W-1:0];
                    end
                    if (cnt_reg == 6'd6)
                    begin
                        state_reg <= ST_BOX;
                    end
                end
                ST_BOX:
                begin
                    box_left_reg   <= minx[FRAC_BITS+COORD_W-1:FRAC_BITS];
                    box_top_reg    <= miny[FRAC_BITS+COORD_W-1:FRAC_BITS];
                    box_right_reg  <= (rx < {1'b0, w_eff}) ? rx[COORD_W-1:0] : w_eff;
                    box_bottom_reg <= (ry < {1'b0, h_eff}) ? ry[COORD_W-1:0] : h_eff;
                    scan_col_reg   <= minx[FRAC_BITS+COORD_W-1:FRAC_BITS];
                    scan_row_reg   <= miny[FRAC_BITS+COORD_W-1:FRAC_BITS];
                    sidx_reg       <= '0;
                    cnt_reg        <= '0;
                    state_reg      <= ST_AREA;
                end
                ST_AREA:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        t_reg <= prod;
                    end
                    if (cnt_reg == 6'd2)
                    begin
                        neg_reg  <= diff[PROD_W-1];
                        dmag_reg <= diff[PROD_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
                        norm_reg <= diff[PROD_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
                        nshift_reg <= '0;
                        if (diff == '0)
                        begin
                            // degenerate: empty box
                            box_bottom_reg <= box_top_reg;
                            rcp_reg        <= '0;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (norm_reg[MAG_W-1])
                    begin
                        shift_reg <= SH_W'(MAG_W + RCP_SCALE - FRAC_BITS) - SH_W'(nshift_reg);
                        rem_reg   <= (MAG_W + 1)'(1) << (MAG_W - 1);
                        rcp_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        norm_reg   <= {norm_reg[MAG_W-2:0], 1'b0};
                        nshift_reg <= nshift_reg + 6'd1;
                    end
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit per beat
                    rem_reg <= div_ge ? r_sh - {1'b0, norm_reg} : r_sh;
                    rcp_reg <= {rcp_reg[MAG_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(MAG_W - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK:
                begin
                    if (scan_row_reg >= box_bottom_reg)
                    begin
                        res_hit_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                    else if (scan_col_reg >= box_right_reg)
                    begin
                        scan_row_reg <= scan_row_reg + COORD_W'(1);
                        scan_col_reg <= box_left_reg;
                    end
                    else if (sidx_reg >= s_eff)
                    begin
                        scan_col_reg <= scan_col_reg + COORD_W'(1);
                        sidx_reg     <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_POINT;
                    end
                end
                ST_POINT:
                begin
                    px_reg    <= {scan_col_reg[PIX_W-1:0], off_x};
                    py_reg    <= {scan_row_reg[PIX_W-1:0], off_y};
                    cnt_reg   <= '0;
                    state_reg <= ST_EDGE;
                end
                ST_EDGE:
                begin
                    cnt_reg <= (cnt_reg == 6'd4) ? '0 : cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1 || cnt_reg == 6'd3)
                    begin
                        t_reg <= prod;
                    end
                    if (cnt_reg == 6'd2)
                    begin
                        vn_reg <= diff_abs;
                    end
                    if (cnt_reg == 6'd4)
                    begin
                        wn_reg   <= diff_abs;
                        sidx_reg <= sidx_reg + SCNT_W'(1);
                        acc_reg  <= '0;
                        state_reg <= covered ? ST_WEIGHT : ST_WALK;
                    end
                end
                ST_WEIGHT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd4)
                    begin
                        bv_reg  <= wsat;
                        acc_reg <= '0;
                    end
                    else if (cnt_reg == 6'd8)
                    begin
                        bw_reg      <= wsat;
                        res_hit_reg <= 1'b1;
                        state_reg   <= ST_EMIT;
                    end
                    else if (cnt_reg != '0)
                    begin
                        acc_reg <= acc_sum;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_hit_reg   <= res_hit_reg;
                        out_done_reg  <= !res_hit_reg;
                        out_col_reg   <= res_hit_reg ? scan_col_reg[PIX_W-1:0] : '0;
                        out_row_reg   <= res_hit_reg ? scan_row_reg[PIX_W-1:0] : '0;
                        out_bv_reg    <= res_hit_reg ? bv_reg : '0;
                        out_bw_reg    <= res_hit_reg ? bw_reg : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign empty     = !out_valid_reg;
    assign hit       = out_hit_reg;
    assign done_res  = out_done_reg;
    assign pixel_col = out_col_reg;
    assign pixel_row = out_row_reg;
    assign bary_v    = out_bv_reg;
    assign bary_w    = out_bw_reg;

`ifndef SYNTHESIS
    a_hit_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hit_reg != out_done_reg))
        else $error("result is neither hit nor done, or both");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=>
        (out_valid_reg && $stable(out_bv_reg) && $stable(out_bw_reg) &&
         $stable(out_col_reg) && $stable(out_row_reg) && $stable(out_hit_reg)))
        else $error("waiting result overwritten");

    a_div_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> norm_reg[MAG_W-1])
        else $error("divisor not normalized");
`endif

endmodule

// File: rtl/triangle_sample_rasteriser_top.sv
// Triangle sample rasteriser.
// Input channel (push/full): command 0 loads a triangle, 1 asks for the next
// covered sample, 2 stores one seed word; command 3 is dropped. A short command
// queue takes beats while the walker is busy, so full only rises when it fills.
// Result channel (empty/pop): one beat per next command, hit with pixel and
// barycentric v, w, or done once the box is exhausted. The result register holds
// its beat until popped; the walker stalls only when a second result is ready.
// Config port (cfg_we/cfg_index/cfg_data): frame width, frame height, samples.
// A load takes the beat, scales the vertices, finds the box and forms the area,
// then normalizes and divides, one quotient bit per step; a degenerate load
// stops after the area.
// A next command walks the box and tests each sample with the single shared
// 26x26 multiplier, which forms the edge products in turn; a covered
// sample then has its weights formed from eight partial products and is posted.
// Reset: the box is empty, so a next command answers done; width and height are
// 64 and one centre sample per pixel. Seed words are undefined until written.
module triangle_sample_rasteriser_top #(
    parameter int CMD_QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    command,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_x0,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_y0,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_x1,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_y1,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_x2,
    input  logic [tsr_pkg::VTX_W-1:0]     vertex_y2,
    input  logic [tsr_pkg::SEED_AW-1:0]   seed_index,
    input  logic [tsr_pkg::SEED_W-1:0]    seed_value,
    output logic                          empty,
    input  logic                          pop,
    output logic                          hit,
    output logic                          done_res,
    output logic [tsr_pkg::PIX_W-1:0]     pixel_col,
    output logic [tsr_pkg::PIX_W-1:0]     pixel_row,
    output logic [tsr_pkg::BARY_W-1:0]    bary_v,
    output logic [tsr_pkg::BARY_W-1:0]    bary_w,
    input  logic                          cfg_we,
    input  logic [tsr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [tsr_pkg::CFG_DW-1:0]    cfg_data
);
    import tsr_pkg::*;

    cmd_t      in_cmd;
    cmd_beat_t head;
    logic      take;

    always_comb
    begin
        in_cmd.op         = cmd_code_t'(command);
        in_cmd.vtx[0]     = vertex_x0;
        in_cmd.vtx[1]     = vertex_y0;
        in_cmd.vtx[2]     = vertex_x1;
        in_cmd.vtx[3]     = vertex_y1;
        in_cmd.vtx[4]     = vertex_x2;
        in_cmd.vtx[5]     = vertex_y2;
        in_cmd.seed_index = seed_index;
        in_cmd.seed_value = seed_value;
    end

    tsr_front #(.DEPTH(CMD_QUEUE_DEPTH)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .in_cmd (in_cmd),
        .full   (full),
        .head   (head),
        .take   (take)
    );

    tsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .take      (take),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .hit       (hit),
        .done_res  (done_res),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .bary_v    (bary_v),
        .bary_w    (bary_w)
    );

endmodule

// File: tb/raster_checker.sv
module raster_checker
    import tsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [1:0]           command,
    input  logic [VTX_W-1:0]     vertex_x0,
    input  logic [VTX_W-1:0]     vertex_y0,
    input  logic [VTX_W-1:0]     vertex_x1,
    input  logic [VTX_W-1:0]     vertex_y1,
    input  logic [VTX_W-1:0]     vertex_x2,
    input  logic [VTX_W-1:0]     vertex_y2,
    input  logic [SEED_AW-1:0]   seed_index,
    input  logic [SEED_W-1:0]    seed_value,
    input  logic                 empty,
    input  logic                 pop,
    input  logic                 hit,
    input  logic                 done_res,
    input  logic [PIX_W-1:0]     pixel_col,
    input  logic [PIX_W-1:0]     pixel_row,
    input  logic [BARY_W-1:0]    bary_v,
    input  logic [BARY_W-1:0]    bary_w,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   hit_count,
    output int                   done_count
);

    typedef logic [63:0] u64_t;

    typedef struct packed {
        logic              hit;
        logic              done;
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [BARY_W-1:0] v;
        logic [BARY_W-1:0] w;
    } sample_beat_t;

    logic [6:0]  frame_w;
    logic [6:0]  frame_h;
    logic [4:0]  samples_reg;
    u64_t        img [6];
    u64_t        area_rcp;
    int unsigned area_bits;
    bit          area_neg;
    int unsigned box_l, box_r, box_t, box_b;
    int unsigned scan_x, scan_y, sample_no;
    logic [31:0] seed_words [SEED_DEPTH];
    sample_beat_t expected_samples [$];

    function automatic int unsigned eff_w();
        return (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    endfunction

    function automatic int unsigned eff_h();
        return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    endfunction

    function automatic int unsigned eff_samples();
        if (samples_reg == 0)
            return 1;
        return (samples_reg > MAX_SAMPLES) ? MAX_SAMPLES : samples_reg;
    endfunction

    function automatic logic [31:0] vdc_frac(logic [31:0] n, logic [31:0] scr);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
            r[i] = n[31-i];
        return r ^ scr;
    endfunction

    function automatic logic [31:0] sobol2_frac(logic [31:0] n, logic [31:0] scr);
        logic [31:0] dir;
        dir = 32'h8000_0000;
        while (n != 0)
        begin
            if (n[0])
                scr ^= dir;
            n >>= 1;
            dir ^= dir >> 1;
        end
        return scr;
    endfunction

    function automatic u64_t twice_area();
        return (img[2] - img[0]) * (img[5] - img[1]) - (img[4] - img[0]) * (img[3] - img[1]);
    endfunction

    function automatic u64_t bary_weight(u64_t num);
        logic [127:0] prod;
        u64_t q;
        prod = {64'd0, num} * {64'd0, area_rcp};
        q = u64_t'(prod >> (area_bits + RCP_SCALE - FRAC_BITS));
        return (q > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : q;
    endfunction

    task automatic set_up_triangle();
        u64_t w, h, minx, maxx, miny, maxy, d, mag, r, q;
        int unsigned s;
        w = eff_w();
        h = eff_h();
        img[0] = vertex_x0 * w;
        img[1] = vertex_y0 * h;
        img[2] = vertex_x1 * w;
        img[3] = vertex_y1 * h;
        img[4] = vertex_x2 * w;
        img[5] = vertex_y2 * h;
        minx = img[0]; maxx = img[0];
        miny = img[1]; maxy = img[1];
        for (int i = 1; i < 3; i++)
        begin
            if (img[2*i] < minx) minx = img[2*i];
            if (img[2*i] > maxx) maxx = img[2*i];
            if (img[2*i+1] < miny) miny = img[2*i+1];
            if (img[2*i+1] > maxy) maxy = img[2*i+1];
        end
        box_l = minx >> FRAC_BITS;
        box_t = miny >> FRAC_BITS;
        box_r = ((maxx >> FRAC_BITS) + 1 < w) ? (maxx >> FRAC_BITS) + 1 : w;
        box_b = ((maxy >> FRAC_BITS) + 1 < h) ? (maxy >> FRAC_BITS) + 1 : h;
        d = twice_area();
        area_neg = d[63];
        mag = area_neg ? -d : d;
        area_rcp = 0;
        area_bits = 1;
        if (mag == 0 || mag[63])
            box_b = box_t;
        else
        begin
            s = 0;
            while (s < 63 && (mag >> s) != 0)
                s++;
            // restoring divide, 48 quotient bits
            r = 64'd1 << (s - 1);
            q = 0;
            for (int i = 0; i <= RCP_SCALE + 1; i++)
            begin
                if (i != 0)
                    r <<= 1;
                q <<= 1;
                if (r >= mag)
                begin
                    r -= mag;
                    q |= 1;
                end
            end
            area_rcp = q;
            area_bits = s;
        end
        scan_x = box_l;
        scan_y = box_t;
        sample_no = 0;
    endtask

    function automatic bit sample_covered(output u64_t vo, output u64_t wo);
        u64_t px, py, vn, wn, dmag;
        int unsigned pix;
        vo = 0;
        wo = 0;
        px = u64_t'(scan_x) << FRAC_BITS;
        py = u64_t'(scan_y) << FRAC_BITS;
        if (eff_samples() > 1)
        begin
            pix = (scan_y * eff_w() + scan_x) % BANK_DEPTH;
            px += vdc_frac(sample_no, seed_words[2*pix]) >> (32 - FRAC_BITS);
            py += sobol2_frac(sample_no, seed_words[2*pix+1]) >> (32 - FRAC_BITS);
        end
        else
        begin
            px += 64'd1 << (FRAC_BITS - 1);
            py += 64'd1 << (FRAC_BITS - 1);
        end
        vn = (img[4] - px) * (img[1] - py) - (img[0] - px) * (img[5] - py);
        wn = (img[0] - px) * (img[3] - py) - (img[2] - px) * (img[1] - py);
        if (area_neg)
        begin
            vn = -vn;
            wn = -wn;
        end
        if (vn[63] || wn[63] || area_rcp == 0)
            return 0;
        dmag = twice_area();
        if (area_neg)
            dmag = -dmag;
        if (u64_t'(vn + wn) > dmag)
            return 0;
        vo = bary_weight(vn);
        wo = bary_weight(wn);
        return 1;
    endfunction

    function automatic sample_beat_t next_covered_sample();
        sample_beat_t b;
        u64_t bv, bw;
        bit cov;
        b = '0;
        while (scan_y < box_b)
        begin
            while (scan_x < box_r)
            begin
                while (sample_no < eff_samples())
                begin
                    cov = sample_covered(bv, bw);
                    sample_no++;
                    if (cov)
                    begin
                        b.hit = 1;
                        b.col = scan_x[PIX_W-1:0];
                        b.row = scan_y[PIX_W-1:0];
                        b.v = bv[BARY_W-1:0];
                        b.w = bw[BARY_W-1:0];
                        return b;
                    end
                end
                scan_x++;
                sample_no = 0;
            end
            scan_y++;
            scan_x = box_l;
        end
        b.done = 1;
        return b;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_beat_t want;
        if (!rst_n)
        begin
            frame_w = MAX_WIDTH;
            frame_h = MAX_HEIGHT;
            samples_reg = 1;
            foreach (img[i])
                img[i] = 0;
            area_rcp = 0;
            area_bits = 1;
            area_neg = 0;
            box_l = 0; box_r = 0; box_t = 0; box_b = 0;
            scan_x = 0; scan_y = 0; sample_no = 0;
            expected_samples.delete();
            errors = 0;
            pending = 0;
            hit_count = 0;
            done_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("result beat with nothing expected", hit, 0);
                else
                begin
                    want = expected_samples.pop_front();
                    if (hit !== want.hit)        report_mismatch("hit", hit, want.hit);
                    if (done_res !== want.done)  report_mismatch("done_res", done_res, want.done);
                    if (pixel_col !== want.col)  report_mismatch("pixel_col", pixel_col, want.col);
                    if (pixel_row !== want.row)  report_mismatch("pixel_row", pixel_row, want.row);
                    if (bary_v !== want.v)       report_mismatch("bary_v", bary_v, want.v);
                    if (bary_w !== want.w)       report_mismatch("bary_w", bary_w, want.w);
                    if (want.hit)
                        hit_count++;
                    else
                        done_count++;
                end
            end
            if (push && !full)
            begin
                case (cmd_code_t'(command))
                    CMD_LOAD: set_up_triangle();
                    CMD_NEXT: expected_samples.push_back(next_covered_sample());
                    CMD_SEED: seed_words[seed_index] = seed_value;
                    default: ;
                endcase
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w = cfg_data;
                    REG_FRAME_HEIGHT: frame_h = cfg_data;
                    REG_SAMPLE_COUNT: samples_reg = cfg_data[4:0];
                    default: ;
                endcase
            end
            pending = expected_samples.size();
        end
    end

endmodule

// File: tb/triangle_sample_rasteriser_top_test.sv
module triangle_sample_rasteriser_top_test;
    import tsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int FULL_Q         = 65536;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                push = 0;
    logic                full;
    logic [1:0]          command = CMD_NONE;
    logic [VTX_W-1:0]    vertex_x0 = 0, vertex_y0 = 0, vertex_x1 = 0;
    logic [VTX_W-1:0]    vertex_y1 = 0, vertex_x2 = 0, vertex_y2 = 0;
    logic [SEED_AW-1:0]  seed_index = 0;
    logic [SEED_W-1:0]   seed_value = 0;
    logic                empty;
    logic                pop = 0;
    logic                hit, done_res;
    logic [PIX_W-1:0]    pixel_col, pixel_row;
    logic [BARY_W-1:0]   bary_v, bary_w;
    logic                cfg_we = 0;
    logic [CFG_IW-1:0]   cfg_index = 0;
    logic [CFG_DW-1:0]   cfg_data = 0;

    int errors, pending, hit_count, done_count;
    int items_sent = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 62;
    bit recv_hold = 0;
    bit seeded [SEED_DEPTH];
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    triangle_sample_rasteriser_top u_top (.*);

    raster_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("triangle_sample_rasteriser_top_test NOT OK");
            $finish;
        end
    end

    // result side: random pop, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (recv_hold)
            begin
                pop = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                recv_hold = 0;
            end
            else
                pop = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(cmd_code_t op, int x0, int y0, int x1, int y1, int x2, int y2,
                             int sidx, logic [31:0] sval);
        bit taken;
        // idling mode follows progress through the run
        if (items_sent < 650)
        begin
            send_idle_pct = 16;
            recv_idle_pct = 62;
        end
        else if (items_sent < 1300)
        begin
            send_idle_pct = 62;
            recv_idle_pct = 16;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push = 0;
            @(negedge clk);
        end
        push = 1;
        command = op;
        vertex_x0 = x0; vertex_y0 = y0;
        vertex_x1 = x1; vertex_y1 = y1;
        vertex_x2 = x2; vertex_y2 = y2;
        seed_index = sidx;
        seed_value = sval;
        if (op == CMD_SEED)
            seeded[sidx] = 1;
        // full is stable from the falling edge up to the next rising edge
        do
        begin
            taken = !full;
            @(negedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic send_next();
        send_beat(CMD_NEXT, $urandom_range(0, FULL_Q), $urandom_range(0, FULL_Q),
                  $urandom_range(0, FULL_Q), $urandom_range(0, FULL_Q),
                  $urandom_range(0, FULL_Q), $urandom_range(0, FULL_Q),
                  $urandom_range(0, SEED_DEPTH - 1), $urandom);
    endtask

    task automatic send_load(int x0, int y0, int x1, int y1, int x2, int y2);
        send_beat(CMD_LOAD, x0, y0, x1, y1, x2, y2, $urandom_range(0, SEED_DEPTH - 1), $urandom);
    endtask

    task automatic send_seed(int sidx, logic [31:0] sval);
        send_beat(CMD_SEED, $urandom_range(0, FULL_Q), 0, 0, FULL_Q, 0, 0, sidx, sval);
    endtask

    function automatic int coord_near(int c, int span);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        return (v < 0) ? 0 : (v > FULL_Q) ? FULL_Q : v;
    endfunction

    function automatic int coord_any();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return FULL_Q;
            default: return $urandom_range(0, FULL_Q);
        endcase
    endfunction

    task automatic send_random_triangle();
        int c[6];
        int kind, cx, cy, span;
        kind = $urandom_range(0, 99);
        cx = $urandom_range(0, FULL_Q);
        cy = $urandom_range(0, FULL_Q);
        span = $urandom_range(0, 12000);
        for (int i = 0; i < 6; i++)
        begin
            if (kind < 55)
                c[i] = coord_near((i % 2) ? cy : cx, span);
            else
                c[i] = coord_any();
        end
        if (kind >= 92)
        begin
            // degenerate: repeated or collinear corner
            c[4] = c[0];
            c[5] = c[1];
            if (kind >= 96)
            begin
                c[2] = c[0];
                c[3] = c[1];
            end
        end
        send_load(c[0], c[1], c[2], c[3], c[4], c[5]);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        push = 0;
        @(negedge clk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic run_phase(int w, int h, int sc, int count, bit do_hold, bit do_pause);
        int words, n, k;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_SAMPLE_COUNT, sc);
        // every seed word a walk may read is written first
        if (sc[4:0] > 1)
        begin
            words = 2 * ((w > MAX_WIDTH) ? MAX_WIDTH : w) * ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
            for (int i = 0; i < words; i++)
                if (!seeded[i])
                    send_seed(i, $urandom);
        end
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 4)
            begin
                send_beat(CMD_NONE, coord_any(), coord_any(), coord_any(), coord_any(),
                          coord_any(), coord_any(), $urandom_range(0, SEED_DEPTH - 1), $urandom);
                n++;
            end
            else if (k < 10)
            begin
                send_seed($urandom_range(0, SEED_DEPTH - 1), $urandom);
                n++;
            end
            else
            begin
                send_random_triangle();
                k = $urandom_range(1, 12);
                for (int i = 0; i < k; i++)
                    send_next();
                n += k + 1;
            end
            if (do_hold && n > count / 2)
            begin
                do_hold = 0;
                send_random_triangle();
                recv_hold = 1;
                for (int i = 0; i < 10; i++)
                    send_next();
                n += 11;
            end
            if (do_pause && n > count / 3)
            begin
                do_pause = 0;
                push = 0;
                @(negedge clk);
                wait_drained();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed part, default registers
        send_next();
        send_load(0, 0, FULL_Q, 0, 0, FULL_Q);
        send_next();
        send_next();
        send_next();
        send_load(0, 0, 0, FULL_Q, FULL_Q, 0);
        send_next();
        send_next();
        send_load(FULL_Q, FULL_Q, FULL_Q, 0, 0, FULL_Q);
        send_next();
        send_load(5000, 5000, 5000, 5000, 5000, 5000);
        send_next();
        send_load(100, 100, 400, 100, 100, 400);
        send_next();
        send_next();
        send_beat(CMD_NONE, FULL_Q, FULL_Q, FULL_Q, FULL_Q, FULL_Q, FULL_Q, 8191, '1);
        send_seed(0, 32'h0);
        send_seed(SEED_DEPTH - 1, 32'hffff_ffff);
        send_load(0, 0, 65535, 0, 0, 65535);
        send_next();
        send_next();

        run_phase(8, 8, 4, 240, 1, 0);
        run_phase(1, 1, 16, 200, 0, 1);
        run_phase(127, 1, 0, 200, 0, 0);
        run_phase(5, 3, 31, 230, 0, 0);
        run_phase(0, 64, 2, 120, 0, 0);
        run_phase(64, 64, 1, 300, 1, 0);
        run_phase(16, 4, 8, 260, 0, 1);
        run_phase(3, 7, 16, 240, 0, 0);

        wait_idle();
        $display("covered %0d commands over eight frame and sample settings", items_sent);
        $display("checked %0d covered samples and %0d done beats", hit_count, done_count);
        if (errors == 0)
            $display("triangle_sample_rasteriser_top_test OK");
        else
            $display("triangle_sample_rasteriser_top_test NOT OK");
        $finish;
    end

endmodule
